// ----- design/ohr_pkg.sv -----
// ----------------------------------------------------------------------------
// ohr_pkg: shared types and constants of the overwriting history ring
// Field widths, request codes and the structs that pass between the
// controller, the entry store and the top level.
// ----------------------------------------------------------------------------
package ohr_pkg;

	// Field widths of the request and result channels.
	localparam int REQ_W  = 2;
	localparam int DATA_W = 32;
	localparam int OFS_W  = 8;
	localparam int SER_W  = 64;
	localparam int CNT_W  = 9;

	// Request codes. The fourth code is unused and changes nothing.
	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH      = 2'd0,
		REQ_BY_OFFSET = 2'd1,
		REQ_BY_SERIAL = 2'd2
	} req_kind_t;

	// Access to the entry store for one request.
	typedef struct packed {
		logic             rd;
		logic             wr;
		logic [CNT_W-1:0] slot;
	} mem_cmd_t;

	// Result of one request, apart from the data read from the store.
	typedef struct packed {
		logic             ok;
		logic             push;
		logic             rd;
		logic [SER_W-1:0] assigned;
		logic [CNT_W-1:0] count;
		logic [SER_W-1:0] oldest;
		logic [SER_W-1:0] newest;
	} res_t;

endpackage

// ----- design/ohr_req_if.sv -----
// ----------------------------------------------------------------------------
// ohr_req_if: request channel of the overwriting history ring
// Valid/ready handshake carrying one request.
// ----------------------------------------------------------------------------
interface ohr_req_if import ohr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [DATA_W-1:0] entry_data;
	logic [OFS_W-1:0]  read_offset;
	logic [SER_W-1:0]  read_serial;

	modport source (
		output valid, req_type, entry_data, read_offset, read_serial,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_data, read_offset, read_serial,
		output ready
	);
endinterface

// ----- design/ohr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ohr_rsp_if: result channel of the overwriting history ring
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface ohr_rsp_if import ohr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ok;
	logic [DATA_W-1:0] read_data;
	logic [SER_W-1:0]  assigned_serial;
	logic [CNT_W-1:0]  entry_count;
	logic [SER_W-1:0]  oldest_serial;
	logic [SER_W-1:0]  newest_serial;

	modport source (
		output valid, ok, read_data, assigned_serial, entry_count,
		       oldest_serial, newest_serial,
		input  ready
	);
	modport sink (
		input  valid, ok, read_data, assigned_serial, entry_count,
		       oldest_serial, newest_serial,
		output ready
	);
endinterface

// ----- design/overwriting_history_ring.sv -----
// ----------------------------------------------------------------------------
// overwriting_history_ring: history buffer with serial numbers
// Results are registered: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle, set by the single store port and the
// registered update of the ring counters; a stalled result holds the input.
// Reset: asynchronous, active low; empties the ring, serial counter to 1,
// capacity to 256 or MAX_DEPTH if smaller. The entry store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module overwriting_history_ring import ohr_pkg::*; #(
	parameter int MAX_DEPTH   = 256,
	parameter int ENTRY_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	ohr_req_if.sink          req,
	ohr_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// Stored width: entries are cut to ENTRY_WIDTH, the data field is 32 bits.
	localparam int SW = (ENTRY_WIDTH < DATA_W) ? ENTRY_WIDTH : DATA_W;

	mem_cmd_t        cmd;
	logic            res_valid;
	res_t            res;
	logic [SW-1:0]   wdata, rdata;

	assign wdata = req.entry_data[SW-1:0];

	ohr_ctrl #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_ready (rsp.ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res)
	);

	ohr_store #(
		.DEPTH (MAX_DEPTH),
		.WIDTH (SW)
	) u_store (
		.clk   (clk),
		.cmd   (cmd),
		.wdata (wdata),
		.rdata (rdata)
	);

	// Result channel; read data only for a successful read.
	assign rsp.valid           = res_valid;
	assign rsp.ok              = res.ok;
	assign rsp.read_data       = (res.ok && res.rd) ? DATA_W'(rdata) : '0;
	assign rsp.assigned_serial = res.assigned;
	assign rsp.entry_count     = res.count;
	assign rsp.oldest_serial   = res.oldest;
	assign rsp.newest_serial   = res.newest;

	// A pushed entry becomes the newest one.
	a_push_newest: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && res.push |-> rsp.assigned_serial == rsp.newest_serial
			&& rsp.entry_count != '0)
		else $error("push result does not report its serial as newest");

	// The serial range spans exactly the held entries.
	a_serial_span: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.entry_count != '0 |->
			rsp.newest_serial - rsp.oldest_serial == SER_W'(rsp.entry_count - CNT_W'(1)))
		else $error("serial range disagrees with entry count");

	// An empty ring reports zero serials.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.entry_count == '0 |->
			rsp.oldest_serial == '0 && rsp.newest_serial == '0)
		else $error("empty ring reports nonzero serials");

	// The store is read only for a request that then reports success.
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> rsp.valid && rsp.ok && res.rd)
		else $error("store read without a successful read result");

endmodule

// ----- design/ohr_store.sv -----
// ----------------------------------------------------------------------------
// ohr_store: entry memory of the overwriting history ring
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ohr_store import ohr_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  mem_cmd_t         cmd,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [AW-1:0]    addr;

	// Slots that are accessed lie below the capacity, which never exceeds the depth.
	assign addr = AW'(cmd.slot);

	// One access per cycle: write or registered read.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ohr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ohr_ctrl: ring controller of the overwriting history ring
// Holds occupancy, oldest slot and serial counters, decodes each request,
// computes the store slot and registers the result fields.
// ----------------------------------------------------------------------------
module ohr_ctrl import ohr_pkg::*; #(
	parameter int MAX_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	ohr_req_if.sink          req,
	input  logic             out_ready,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output mem_cmd_t         cmd,
	output logic             res_valid,
	output res_t             res
);

	// Capacity as used: zero acts as one, anything above the depth as the depth.
	function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] c;
		if (v == '0) begin
			c = CNT_W'(1);
		end else if (int'(v) > MAX_DEPTH) begin
			c = CNT_W'(MAX_DEPTH);
		end else begin
			c = v;
		end
		return c;
	endfunction

	localparam logic [CNT_W-1:0] CAP_RST = clamp_cap(CNT_W'(256));

	logic [CNT_W-1:0] cap_q, held_q, oslot_q;
	logic [SER_W-1:0] next_q, base_q, last_q;
	logic             vld_s1;
	res_t             res_s1;

	logic             acc, is_full, ofs_hit, srl_hit;
	logic [SER_W-1:0] srl_diff;
	logic [CNT_W-1:0] opnd, slot, oslot_adv;
	logic [CNT_W:0]   sum, inc;
	logic [CNT_W-1:0] held_n, oslot_n;
	logic [SER_W-1:0] next_n, base_n, last_n;
	res_t             res_n;

	assign req.ready = !vld_s1 || out_ready;
	assign acc       = req.valid && req.ready;

	// Request decode, slot arithmetic and next state.
	always_comb begin
		is_full  = (held_q == cap_q);
		srl_diff = req.read_serial - base_q;
		srl_hit  = (srl_diff[SER_W-1:CNT_W] == '0) && (srl_diff[CNT_W-1:0] < held_q);
		ofs_hit  = ({1'b0, req.read_offset} < held_q);

		opnd    = '0;
		cmd.rd  = 1'b0;
		cmd.wr  = 1'b0;
		held_n  = held_q;
		oslot_n = oslot_q;
		next_n  = next_q;
		base_n  = base_q;
		last_n  = last_q;
		res_n   = '0;

		// Advance of the oldest slot when a full ring overwrites.
		inc       = {1'b0, oslot_q} + (CNT_W+1)'(1);
		oslot_adv = (inc == {1'b0, cap_q}) ? '0 : inc[CNT_W-1:0];

		case (req.req_type)
			REQ_PUSH: begin
				res_n.ok   = 1'b1;
				res_n.push = 1'b1;
				res_n.assigned = next_q;
				cmd.wr = acc;
				next_n = next_q + SER_W'(1);
				last_n = next_q;
				if (is_full) begin
					base_n  = base_q + SER_W'(1);
					oslot_n = oslot_adv;
				end else begin
					opnd   = held_q;
					held_n = held_q + CNT_W'(1);
				end
			end
			REQ_BY_OFFSET: begin
				res_n.ok = ofs_hit;
				res_n.rd = 1'b1;
				opnd     = {1'b0, req.read_offset};
				cmd.rd   = acc && ofs_hit;
			end
			REQ_BY_SERIAL: begin
				res_n.ok = srl_hit;
				res_n.rd = 1'b1;
				opnd     = srl_diff[CNT_W-1:0];
				cmd.rd   = acc && srl_hit;
			end
			default: begin
			end
		endcase

		// For an access both operands lie below the capacity, so one subtract wraps the sum.
		sum  = {1'b0, oslot_q} + {1'b0, opnd};
		slot = (sum >= {1'b0, cap_q}) ? CNT_W'(sum - {1'b0, cap_q}) : sum[CNT_W-1:0];
		cmd.slot = slot;

		res_n.count  = held_n;
		res_n.oldest = (held_n != '0) ? base_n : '0;
		res_n.newest = (held_n != '0) ? last_n : '0;
	end

	// Ring state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RST;
			held_q  <= '0;
			oslot_q <= '0;
			next_q  <= SER_W'(1);
			base_q  <= SER_W'(1);
			last_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= clamp_cap(cfg_wdata);
				held_q  <= '0;
				oslot_q <= '0;
				base_q  <= next_q;
			end else if (acc) begin
				held_q  <= held_n;
				oslot_q <= oslot_n;
				next_q  <= next_n;
				base_q  <= base_n;
				last_q  <= last_n;
			end
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (out_ready) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Result payload; no reset needed.
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_n;
		end
	end

	assign res_valid = vld_s1;
	assign res       = res_s1;

endmodule
